@@ rtl/qfc_pkg.sv @@
// ----------------------------------------------------------------------------
// qfc_pkg
// Shared types and constants for the Q7 full convolution core.
// ----------------------------------------------------------------------------
`default_nettype none

package qfc_pkg;

  // Opcodes carried in the input beat.
  localparam logic OP_SIGNAL = 1'b0;
  localparam logic OP_TAP    = 1'b1;

  // Q7 scaling and output saturation limits.
  localparam int Q_SHIFT = 7;
  localparam int SAT_MAX = 127;
  localparam int SAT_MIN = -128;

  typedef struct packed {
    logic              opcode;
    logic signed [7:0] sample;
    logic              last;
  } in_t;

  typedef struct packed {
    logic signed [7:0] value;
    logic              final_res;
  } out_t;

  // Controls broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic signed [7:0] tap_data;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/q7_full_convolution_core.sv @@
// ----------------------------------------------------------------------------
// q7_full_convolution_core
// Full linear convolution of a signed Q7 signal with a stored Q7 kernel.
// ----------------------------------------------------------------------------
// Each input beat carries either a kernel tap or a signal sample. Taps are
// written into the chain of cells in arrival order; the tap flagged last
// sets the kernel length, and taps beyond KERNEL_MAX are dropped. A signal
// sample shifts into the history line and produces one output beat, the
// product sum shifted right by 7 and saturated to the Q7 range. The last
// sample of a sequence also produces kernel length minus one tail beats,
// computed as if zeros were shifted in, with final_res set on the very last
// one; the history is then cleared. Every result is formed by a partial sum
// that travels through the KERNEL_MAX cells, one cell per cycle. Input is
// stalled while a result is in flight, but a new beat is accepted while a
// finished result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module q7_full_convolution_core import qfc_pkg::*; #(
  parameter int KERNEL_MAX = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  // Index and length registers must also hold KERNEL_MAX itself.
  localparam int IDX_W = $clog2(KERNEL_MAX + 1);
  // Enough headroom for KERNEL_MAX full-scale products.
  localparam int ACC_W = 17 + $clog2(KERNEL_MAX);
  localparam logic [IDX_W-1:0]        MAX_IDX = IDX_W'(KERNEL_MAX);
  localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(SAT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(SAT_MIN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  state_t            state_r;
  logic              start_r;
  logic [IDX_W-1:0]  len_r;
  logic [IDX_W-1:0]  load_idx_r;
  logic [IDX_W-1:0]  tail_cnt_r;
  logic              last_seq_r;
  logic              out_valid_r;
  out_t              out_data_r;
  logic signed [7:0] val_r;

  logic in_acc;
  logic sig_acc;
  logic tap_acc;
  logic out_free;
  logic more_tail;
  logic emit;

  cell_ctl_t ctl;

  // Chain wiring: element k feeds cell k, element k+1 is cell k's output.
  logic signed [7:0]       hist_c [KERNEL_MAX+1];
  logic signed [ACC_W-1:0] psum_c [KERNEL_MAX+1];
  logic                    tok_c  [KERNEL_MAX+1];

  logic signed [ACC_W-1:0] shifted;
  logic signed [7:0]       sat_val;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign sig_acc   = in_acc && (in_data.opcode == OP_SIGNAL);
  assign tap_acc   = in_acc && (in_data.opcode == OP_TAP);
  assign out_free  = !out_valid_r || !out_stall;
  assign more_tail = (tail_cnt_r != '0);
  assign emit      = (state_r == S_WAIT) && out_free;

  // A new sample or a tail zero shifts the history; the last output of a
  // sequence wipes it.
  assign ctl.shift    = sig_acc || (emit && more_tail);
  assign ctl.clear    = emit && !more_tail && last_seq_r;
  assign ctl.tap_data = in_data.sample;

  assign hist_c[0] = sig_acc ? in_data.sample : 8'sd0;
  assign psum_c[0] = '0;
  assign tok_c[0]  = start_r;

  for (genvar k = 0; k < KERNEL_MAX; k++) begin : g_cell
    logic tap_we;
    logic tap_en;

    assign tap_we = tap_acc && (load_idx_r == IDX_W'(k));
    assign tap_en = (IDX_W'(k) < len_r);

    qfc_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .tap_we   (tap_we),
      .tap_en   (tap_en),
      .hist_in  (hist_c[k]),
      .hist_out (hist_c[k+1]),
      .tok_in   (tok_c[k]),
      .psum_in  (psum_c[k]),
      .tok_out  (tok_c[k+1]),
      .psum_out (psum_c[k+1])
    );
  end

  // Arithmetic shift rounds toward minus infinity, then clamp to Q7.
  always_comb begin
    shifted = psum_c[KERNEL_MAX] >>> Q_SHIFT;
    if (shifted > SAT_HI) begin
      sat_val = 8'sd127;
    end else if (shifted < SAT_LO) begin
      sat_val = -8'sd128;
    end else begin
      sat_val = shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      len_r       <= IDX_W'(1);
      load_idx_r  <= '0;
      tail_cnt_r  <= '0;
      last_seq_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (tap_acc) begin
            if (load_idx_r < MAX_IDX) begin
              load_idx_r <= load_idx_r + IDX_W'(1);
            end
            if (in_data.last) begin
              len_r      <= (load_idx_r < MAX_IDX) ? load_idx_r + IDX_W'(1) : MAX_IDX;
              load_idx_r <= '0;
            end
          end
          if (sig_acc) begin
            tail_cnt_r <= in_data.last ? len_r - IDX_W'(1) : '0;
            last_seq_r <= in_data.last;
            start_r    <= 1'b1;
            state_r    <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok_c[KERNEL_MAX]) begin
            val_r   <= sat_val;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_data_r.value     <= val_r;
            out_data_r.final_res <= !more_tail && last_seq_r;
            if (more_tail) begin
              tail_cnt_r <= tail_cnt_r - IDX_W'(1);
              start_r    <= 1'b1;
              state_r    <= S_RUN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/qfc_cell.sv @@
// ----------------------------------------------------------------------------
// qfc_cell
// One cell of the convolution chain: a kernel tap, a history sample and one
// stage of the running product sum.
// ----------------------------------------------------------------------------
`default_nettype none

module qfc_cell import qfc_pkg::*; #(
  parameter int ACC_W = 22
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cell_ctl_t               ctl,
  input  wire logic                    tap_we,
  input  wire logic                    tap_en,
  input  wire logic signed [7:0]       hist_in,
  output logic signed [7:0]            hist_out,
  input  wire logic                    tok_in,
  input  wire logic signed [ACC_W-1:0] psum_in,
  output logic                         tok_out,
  output logic signed [ACC_W-1:0]      psum_out
);

  logic signed [7:0]       tap_r;
  logic signed [7:0]       hist_r;
  logic                    tok_r;
  logic signed [ACC_W-1:0] psum_r;
  logic signed [15:0]      prod;
  logic signed [ACC_W-1:0] psum_nxt;

  assign prod     = tap_r * hist_r;
  assign psum_nxt = psum_in + (tap_en ? ACC_W'(prod) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r  <= '0;
      hist_r <= '0;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (tap_we) begin
        tap_r <= ctl.tap_data;
      end
      if (ctl.clear) begin
        hist_r <= '0;
      end else if (ctl.shift) begin
        hist_r <= hist_in;
      end
    end
  end

  // The partial sum is pure payload; the token says when it is meaningful.
  always_ff @(posedge clk) begin
    psum_r <= psum_nxt;
  end

  assign hist_out = hist_r;
  assign tok_out  = tok_r;
  assign psum_out = psum_r;

endmodule

`default_nettype wire
